// ===== sv/ppts_pkg.sv =====
// Shared types and constants for the per-port traffic statistics engine.
// Used by ppts_ctrl, ppts_dp, per_port_traffic_stats_top, ppts_checker and tb_top; no dependencies.
package ppts_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EV,
        S_SRCH,
        S_FIN,
        S_DUMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic ev;
        logic srch;
        logic fin;
        logic dump;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic port_ok;
        logic ev_last;
        logic srch_done;
        logic dump_last;
    } t_dp_status;

    // Event counter slots inside a port's row.
    localparam int EV_PKTS    = 0;
    localparam int EV_BUCKET0 = 1;
    localparam int EV_OTHER   = 8;
    localparam int EV_UDP     = 9;
    localparam int EV_TCP     = 10;
    localparam int EV_ICMP    = 11;
    localparam int EV_SYN     = 12;
    localparam int EV_SYNACK  = 13;
    localparam int EV_ACK     = 14;
    localparam int EV_FIN     = 15;
    localparam int EV_RST     = 16;
    localparam int EV_NUM     = 17;

    // Dump beat indexes with special sources.
    localparam logic [4:0] CI_PKTS   = 5'd0;
    localparam logic [4:0] CI_BYTES  = 5'd1;
    localparam logic [4:0] CI_IPS    = 5'd18;
    localparam logic [4:0] CI_PORTS  = 5'd19;
    localparam logic [4:0] EV_LASTIX = 5'd16;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_RST = 2;
    localparam int FL_ACK = 4;

    function automatic logic [2:0] len_bucket(input logic [15:0] len);
        logic [2:0] b;
        if (len < 16'd64)        b = 3'd0;
        else if (len < 16'd128)  b = 3'd1;
        else if (len < 16'd256)  b = 3'd2;
        else if (len < 16'd512)  b = 3'd3;
        else if (len < 16'd1024) b = 3'd4;
        else if (len < 16'd1500) b = 3'd5;
        else                     b = 3'd6;
        return b;
    endfunction

endpackage

// ===== sv/ppts_ctrl.sv =====
// Controller state machine of the traffic statistics engine.
// Depends on ppts_pkg; drives ppts_dp through t_dp_cmd.
module ppts_ctrl
    import ppts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_func,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_stat.port_ok) n_state = i_func ? S_DUMP : S_EV;
            end
            S_EV: begin
                if (i_stat.ev_last) n_state = S_SRCH;
            end
            S_SRCH: begin
                if (i_stat.srch_done) n_state = S_FIN;
            end
            S_FIN:  n_state = S_IDLE;
            S_DUMP: begin
                if (i_stat.dump_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_busy     = 1'b1;
        o_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start && i_stat.port_ok;
            end
            S_EV:   o_cmd.ev = 1'b1;
            S_SRCH: o_cmd.srch = 1'b1;
            S_FIN:  o_cmd.fin = 1'b1;
            S_DUMP: begin
                o_cmd.dump = 1'b1;
                o_valid    = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// ===== sv/ppts_dp.sv =====
// Datapath of the traffic statistics engine: counter memories, distinct-value
// tables, search pipeline and dump mux. Depends on ppts_pkg.
module ppts_dp
    import ppts_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int MAX_IPS   = 64,
    parameter int MAX_PORTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_port,
    input  logic [15:0] i_pkt_len,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    output t_dp_status  o_stat,
    output logic [7:0]  o_out_port,
    output logic [4:0]  o_counter_index,
    output logic [63:0] o_counter_value,
    output logic        o_last
);

    localparam int PW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int IW   = (MAX_IPS > 1) ? $clog2(MAX_IPS) : 1;
    localparam int QW   = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CIW  = $clog2(MAX_IPS + 1);
    localparam int CQW  = $clog2(MAX_PORTS + 1);
    localparam int MAXN = (MAX_IPS > MAX_PORTS) ? MAX_IPS : MAX_PORTS;
    localparam int JW   = $clog2(MAXN + 1);

    // Each port owns a row of 32 event slots; only the first EV_NUM are used.
    logic [31:0] ev_mem   [NUM_PORTS*32];
    logic [63:0] byte_mem [NUM_PORTS];
    logic [CIW-1:0] ipc_mem [NUM_PORTS];
    logic [CQW-1:0] pc_mem  [NUM_PORTS];
    logic [31:0] ip_mem   [NUM_PORTS*(2**IW)];
    logic [15:0] dp_mem   [NUM_PORTS*(2**QW)];

    // A port row whose valid bit is low reads as all zero.
    logic [NUM_PORTS-1:0] r_vld;

    logic [PW-1:0]  r_pidx;
    logic [7:0]     r_port;
    logic [15:0]    r_len;
    logic [31:0]    r_sip;
    logic [15:0]    r_dp;
    logic           r_ipv4, r_l4;
    logic [EV_NUM-1:0] r_evb;
    logic [4:0]     r_idx;
    logic [31:0]    r_evq;
    logic [63:0]    r_bq, r_bytes;
    logic [CIW-1:0] r_ipcq, r_ipc;
    logic [CQW-1:0] r_pcq, r_pc;
    logic [JW-1:0]  r_j;
    logic           r_ipchk, r_dpchk, r_iphit, r_dphit;
    logic [31:0]    r_ipq;
    logic [15:0]    r_dpq;

    logic [PW-1:0]      in_pidx;
    logic [EV_NUM-1:0]  evb;
    logic [2:0]         bkt;
    logic               is_ipv4, is_udp, is_tcp, is_icmp;
    logic [PW+4:0]      ev_ra;
    logic               row_ok;
    logic [31:0]        ev_eff;
    logic               ip_act, dp_act;
    logic [JW-1:0]      nip_s, ndp_s, lim;

    assign in_pidx = i_port[PW-1:0];
    assign is_ipv4 = (i_ether_type == ETH_IPV4);
    assign is_udp  = (i_ip_proto == PROTO_UDP);
    assign is_tcp  = (i_ip_proto == PROTO_TCP);
    assign is_icmp = (i_ip_proto == PROTO_ICMP);
    assign bkt     = len_bucket(i_pkt_len);

    always_comb begin
        evb = '0;
        evb[EV_PKTS] = 1'b1;
        evb[EV_BUCKET0 + int'(bkt)] = 1'b1;
        if (!is_ipv4) begin
            evb[EV_OTHER] = 1'b1;
        end else if (is_udp) begin
            evb[EV_UDP] = 1'b1;
        end else if (is_tcp) begin
            evb[EV_TCP]    = 1'b1;
            evb[EV_SYN]    = i_tcp_flags[FL_SYN];
            evb[EV_SYNACK] = i_tcp_flags[FL_SYN] && i_tcp_flags[FL_ACK];
            evb[EV_ACK]    = i_tcp_flags[FL_ACK];
            evb[EV_FIN]    = i_tcp_flags[FL_FIN];
            evb[EV_RST]    = i_tcp_flags[FL_RST];
        end else if (is_icmp) begin
            evb[EV_ICMP] = 1'b1;
        end else begin
            evb[EV_OTHER] = 1'b1;
        end
    end

    always_comb begin
        priority if (i_cmd.load) ev_ra = {in_pidx, 5'd0};
        else if (i_cmd.ev)       ev_ra = {r_pidx, r_idx + 5'd1};
        else                     ev_ra = {r_pidx, r_idx};
    end

    assign row_ok = r_vld[r_pidx];
    assign ev_eff = row_ok ? r_evq : 32'd0;

    assign ip_act = r_ipv4 && (r_ipc < CIW'(MAX_IPS));
    assign dp_act = r_l4 && (r_pc < CQW'(MAX_PORTS));
    assign nip_s  = ip_act ? JW'(r_ipc) : '0;
    assign ndp_s  = dp_act ? JW'(r_pc) : '0;
    assign lim    = (nip_s > ndp_s) ? nip_s : ndp_s;

    // Event memory: every used slot of the row is rewritten during the event
    // walk, so a fresh row is defined wherever it is read once its valid bit is set.
    always_ff @(posedge i_clk) begin
        r_evq <= ev_mem[ev_ra];
        if (i_cmd.ev) begin
            ev_mem[{r_pidx, r_idx}] <= ev_eff + 32'(r_evb[r_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bq   <= byte_mem[in_pidx];
            r_ipcq <= ipc_mem[in_pidx];
            r_pcq  <= pc_mem[in_pidx];
        end
        if (i_cmd.fin) begin
            byte_mem[r_pidx] <= r_bytes;
            ipc_mem[r_pidx]  <= (ip_act && !r_iphit) ? r_ipc + CIW'(1) : r_ipc;
            pc_mem[r_pidx]   <= (dp_act && !r_dphit) ? r_pc + CQW'(1) : r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ipq <= ip_mem[{r_pidx, r_j[IW-1:0]}];
        r_dpq <= dp_mem[{r_pidx, r_j[QW-1:0]}];
        if (i_cmd.fin && ip_act && !r_iphit) ip_mem[{r_pidx, r_ipc[IW-1:0]}] <= r_sip;
        if (i_cmd.fin && dp_act && !r_dphit) dp_mem[{r_pidx, r_pc[QW-1:0]}] <= r_dp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pidx <= in_pidx;
            r_port <= i_port;
            r_len  <= i_pkt_len;
            r_sip  <= i_src_ip;
            r_dp   <= i_dst_port;
            r_ipv4 <= is_ipv4;
            r_l4   <= is_ipv4 && (is_udp || is_tcp);
            r_evb  <= evb;
        end
        if (i_cmd.ev && (r_idx == 5'd0)) begin
            r_bytes <= (row_ok ? r_bq : 64'd0) + 64'(r_len);
            r_ipc   <= row_ok ? r_ipcq : '0;
            r_pc    <= row_ok ? r_pcq : '0;
        end
        r_ipchk <= i_cmd.srch && (r_j < nip_s);
        r_dpchk <= i_cmd.srch && (r_j < ndp_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_idx   <= '0;
            r_j     <= '0;
            r_iphit <= 1'b0;
            r_dphit <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_j     <= '0;
                r_iphit <= 1'b0;
                r_dphit <= 1'b0;
            end else begin
                if (i_cmd.ev || i_cmd.dump) r_idx <= r_idx + 5'd1;
                if (i_cmd.srch) r_j <= r_j + JW'(1);
                if (r_ipchk && (r_ipq == r_sip)) r_iphit <= 1'b1;
                if (r_dpchk && (r_dpq == r_dp)) r_dphit <= 1'b1;
            end
            if (i_cmd.fin) r_vld[r_pidx] <= 1'b1;
            if (i_cmd.dump && (r_idx == CI_PORTS)) r_vld[r_pidx] <= 1'b0;
        end
    end

    assign o_stat.port_ok   = (9'(i_port) < 9'(NUM_PORTS));
    assign o_stat.ev_last   = (r_idx == EV_LASTIX);
    assign o_stat.srch_done = (r_j == lim);
    assign o_stat.dump_last = (r_idx == CI_PORTS);

    always_comb begin
        priority if (r_idx == CI_BYTES) o_counter_value = row_ok ? r_bq : 64'd0;
        else if (r_idx == CI_IPS)  o_counter_value = row_ok ? 64'(r_ipcq) : 64'd0;
        else if (r_idx == CI_PORTS) o_counter_value = row_ok ? 64'(r_pcq) : 64'd0;
        else                       o_counter_value = 64'(ev_eff);
    end

    assign o_out_port      = r_port;
    assign o_counter_index = r_idx;
    assign o_last          = i_cmd.dump && (r_idx == CI_PORTS);

endmodule

// ===== sv/per_port_traffic_stats_top.sv =====
// Per-port traffic statistics engine: controller plus datapath.
// Depends on ppts_pkg, ppts_ctrl and ppts_dp.
//
// Usage: present an item on the i_ fields with start high; it is taken at a
// rising edge where busy is low. Items whose port is at or above NUM_PORTS
// are dropped on the spot and leave busy low.
// A packet item (func 0) produces no beats. It holds busy through the
// event-counter update of the 17 used slots (one slot read and written per
// cycle), then a linear table search, where the distinct-IP and
// distinct-port tables are walked side by side one entry per cycle, then
// a write-back.
// A dump item (func 1) produces 20 beats on the cycles right after
// acceptance, one per cycle, marked by o_valid, with o_last on index 19;
// the port is cleared as the last beat leaves. The receiver cannot stall,
// so each beat is valid for exactly one cycle.
// Reset clears all counters at once through per-port valid bits; no
// clearing pass is needed and the block is ready the cycle after reset.
module per_port_traffic_stats_top
    import ppts_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int MAX_IPS   = 64,
    parameter int MAX_PORTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_port,
    input  logic [15:0] i_pkt_len,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    output logic        o_valid,
    output logic [7:0]  o_out_port,
    output logic [4:0]  o_counter_index,
    output logic [63:0] o_counter_value,
    output logic        o_last
);

    t_dp_cmd    cmd;
    t_dp_status stat;

    ppts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ppts_dp #(
        .NUM_PORTS (NUM_PORTS),
        .MAX_IPS   (MAX_IPS),
        .MAX_PORTS (MAX_PORTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_port          (i_port),
        .i_pkt_len       (i_pkt_len),
        .i_ether_type    (i_ether_type),
        .i_ip_proto      (i_ip_proto),
        .i_src_ip        (i_src_ip),
        .i_dst_port      (i_dst_port),
        .i_tcp_flags     (i_tcp_flags),
        .o_stat          (stat),
        .o_out_port      (o_out_port),
        .o_counter_index (o_counter_index),
        .o_counter_value (o_counter_value),
        .o_last          (o_last)
    );

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("beat outside a busy period");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && o_counter_index == CI_PORTS))
        else $error("last flag on wrong beat");

    a_beat_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=>
            (o_valid && o_counter_index == $past(o_counter_index) + 5'd1))
        else $error("dump beats not consecutive");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !busy) else $error("block still busy after dump");

endmodule

// ===== tb/ppts_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the per-port traffic statistics engine: predicts dump beats.
// Depends on ppts_pkg; instantiated by tb_top beside the block.
module ppts_checker
    import ppts_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int MAX_IPS   = 64,
    parameter int MAX_PORTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_port,
    input  logic [15:0] i_pkt_len,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    input  logic        o_valid,
    input  logic [7:0]  o_out_port,
    input  logic [4:0]  o_counter_index,
    input  logic [63:0] o_counter_value,
    input  logic        o_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_beats,
    output int          o_dumps,
    output int          o_full_sets
);

    typedef struct {
        logic [7:0]  port;
        logic [4:0]  index;
        logic [63:0] value;
        logic        last;
    } t_counter_beat;

    logic [31:0] ev_cnt    [NUM_PORTS][EV_NUM];
    logic [63:0] byte_cnt  [NUM_PORTS];
    logic [31:0] ip_set    [NUM_PORTS][MAX_IPS];
    logic [15:0] dport_set [NUM_PORTS][MAX_PORTS];
    int          ip_cnt    [NUM_PORTS];
    int          dport_cnt [NUM_PORTS];

    t_counter_beat dump_q[$];

    assign o_pending = dump_q.size();

    function automatic void add_ip(int p, logic [31:0] ip);
        bit found;
        found = 0;
        if (ip_cnt[p] >= MAX_IPS) begin
            o_full_sets++;
            return;
        end
        for (int i = 0; i < ip_cnt[p]; i++)
            if (ip_set[p][i] == ip) found = 1;
        if (!found) begin
            ip_set[p][ip_cnt[p]] = ip;
            ip_cnt[p]++;
        end
    endfunction

    function automatic void add_dport(int p, logic [15:0] dp);
        bit found;
        found = 0;
        if (dport_cnt[p] >= MAX_PORTS) return;
        for (int i = 0; i < dport_cnt[p]; i++)
            if (dport_set[p][i] == dp) found = 1;
        if (!found) begin
            dport_set[p][dport_cnt[p]] = dp;
            dport_cnt[p]++;
        end
    endfunction

    function automatic int bucket_of(logic [15:0] len);
        int b;
        if (len < 64)        b = 0;
        else if (len < 128)  b = 1;
        else if (len < 256)  b = 2;
        else if (len < 512)  b = 3;
        else if (len < 1024) b = 4;
        else if (len < 1500) b = 5;
        else                 b = 6;
        return b;
    endfunction

    function automatic void count_packet(int p);
        ev_cnt[p][EV_PKTS]++;
        byte_cnt[p] += 64'(i_pkt_len);
        ev_cnt[p][EV_BUCKET0 + bucket_of(i_pkt_len)]++;
        if (i_ether_type != ETH_IPV4) begin
            ev_cnt[p][EV_OTHER]++;
            return;
        end
        add_ip(p, i_src_ip);
        if (i_ip_proto == PROTO_UDP) begin
            ev_cnt[p][EV_UDP]++;
            add_dport(p, i_dst_port);
        end else if (i_ip_proto == PROTO_TCP) begin
            ev_cnt[p][EV_TCP]++;
            add_dport(p, i_dst_port);
            if (i_tcp_flags[FL_SYN]) ev_cnt[p][EV_SYN]++;
            if (i_tcp_flags[FL_SYN] && i_tcp_flags[FL_ACK]) ev_cnt[p][EV_SYNACK]++;
            if (i_tcp_flags[FL_ACK]) ev_cnt[p][EV_ACK]++;
            if (i_tcp_flags[FL_FIN]) ev_cnt[p][EV_FIN]++;
            if (i_tcp_flags[FL_RST]) ev_cnt[p][EV_RST]++;
        end else if (i_ip_proto == PROTO_ICMP) begin
            ev_cnt[p][EV_ICMP]++;
        end else begin
            ev_cnt[p][EV_OTHER]++;
        end
    endfunction

    // Queues the 20 counter beats of a dump, then clears the port.
    function automatic void dump_port(int p);
        t_counter_beat b;
        for (int k = 0; k < 20; k++) begin
            b.port  = 8'(p);
            b.index = 5'(k);
            b.last  = (5'(k) == CI_PORTS);
            if (5'(k) == CI_PKTS)       b.value = 64'(ev_cnt[p][EV_PKTS]);
            else if (5'(k) == CI_BYTES) b.value = byte_cnt[p];
            else if (5'(k) == CI_IPS)   b.value = 64'(ip_cnt[p]);
            else if (5'(k) == CI_PORTS) b.value = 64'(dport_cnt[p]);
            else                        b.value = 64'(ev_cnt[p][k - 1]);
            dump_q.push_back(b);
        end
        for (int e = 0; e < EV_NUM; e++) ev_cnt[p][e] = '0;
        byte_cnt[p]  = '0;
        ip_cnt[p]    = 0;
        dport_cnt[p] = 0;
        o_dumps++;
    endfunction

    always @(posedge i_clk) begin
        t_counter_beat exp_b;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                for (int e = 0; e < EV_NUM; e++) ev_cnt[p][e] = '0;
                byte_cnt[p]  = '0;
                ip_cnt[p]    = 0;
                dport_cnt[p] = 0;
            end
            dump_q.delete();
            o_errors    = 0;
            o_beats     = 0;
            o_dumps     = 0;
            o_full_sets = 0;
        end else begin
            if (o_valid) begin
                o_beats++;
                if (dump_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected beat port %0d index %0d value %0d last %0b",
                             $time, o_out_port, o_counter_index, o_counter_value, o_last);
                end else begin
                    exp_b = dump_q.pop_front();
                    if (o_out_port !== exp_b.port || o_counter_index !== exp_b.index ||
                        o_counter_value !== exp_b.value || o_last !== exp_b.last) begin
                        o_errors++;
                        $display("%0t: mismatch expected port %0d index %0d value %0d last %0b",
                                 $time, exp_b.port, exp_b.index, exp_b.value, exp_b.last);
                        $display("%0t:          actual   port %0d index %0d value %0d last %0b",
                                 $time, o_out_port, o_counter_index, o_counter_value, o_last);
                    end
                end
            end
            // Out-of-range ports are taken and dropped with no effect.
            if (start && !busy && i_port < NUM_PORTS) begin
                if (i_func) dump_port(int'(i_port));
                else        count_packet(int'(i_port));
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the per-port traffic statistics testbench: clock, reset and stimulus.
// Depends on ppts_pkg, per_port_traffic_stats_top and ppts_checker.
module tb_top
    import ppts_pkg::*;
();

    localparam int NUM_PORTS = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [7:0]  i_port;
    logic [15:0] i_pkt_len;
    logic [15:0] i_ether_type;
    logic [7:0]  i_ip_proto;
    logic [31:0] i_src_ip;
    logic [15:0] i_dst_port;
    logic [7:0]  i_tcp_flags;
    logic        o_valid;
    logic [7:0]  o_out_port;
    logic [4:0]  o_counter_index;
    logic [63:0] o_counter_value;
    logic        o_last;
    int          errors, pending, beats, dumps, full_sets;
    int          idle_pct;

    per_port_traffic_stats_top dut (.*);
    ppts_checker chk (.*, .o_errors(errors), .o_pending(pending), .o_beats(beats),
                      .o_dumps(dumps), .o_full_sets(full_sets));

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // Presents one item and holds it until the block takes it.
    task automatic send(logic func, logic [7:0] port, logic [15:0] len,
                        logic [15:0] etype, logic [7:0] proto, logic [31:0] sip,
                        logic [15:0] dp, logic [7:0] flags);
        int gap;
        start        <= 1'b1;
        i_func       <= func;
        i_port       <= port;
        i_pkt_len    <= len;
        i_ether_type <= etype;
        i_ip_proto   <= proto;
        i_src_ip     <= sip;
        i_dst_port   <= dp;
        i_tcp_flags  <= flags;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pkt(logic [7:0] port, logic [15:0] len, logic [15:0] etype,
                       logic [7:0] proto, logic [31:0] sip, logic [15:0] dp,
                       logic [7:0] flags);
        send(1'b0, port, len, etype, proto, sip, dp, flags);
    endtask

    task automatic dump(logic [7:0] port);
        send(1'b1, port, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
             16'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [7:0]  port;
        logic [15:0] len, etype, dp;
        logic [7:0]  proto, flags;
        logic [31:0] sip;
        int          r;
        port  = ($urandom_range(99) < 6) ? 8'($urandom_range(NUM_PORTS, 255))
                                         : 8'($urandom_range(NUM_PORTS - 1));
        r     = $urandom_range(99);
        len   = (r < 70) ? 16'($urandom_range(1700)) : 16'($urandom);
        etype = ($urandom_range(99) < 80) ? ETH_IPV4 : 16'($urandom);
        r     = $urandom_range(99);
        proto = (r < 35) ? PROTO_TCP : (r < 60) ? PROTO_UDP : (r < 80) ? PROTO_ICMP
                                     : 8'($urandom);
        // A small address pool makes repeats, a few draws span all bits.
        sip   = ($urandom_range(99) < 70) ? {24'h0a0000, 8'($urandom_range(15))} : $urandom;
        dp    = ($urandom_range(99) < 70) ? 16'($urandom_range(20)) : 16'($urandom);
        flags = 8'($urandom);
        if ($urandom_range(99) < 10) dump(port);
        else pkt(port, len, etype, proto, sip, dp, flags);
    endtask

    initial begin
        start        <= 1'b0;
        i_func       <= 1'b0;
        i_port       <= '0;
        i_pkt_len    <= '0;
        i_ether_type <= '0;
        i_ip_proto   <= '0;
        i_src_ip     <= '0;
        i_dst_port   <= '0;
        i_tcp_flags  <= '0;
        i_rst_n      <= 1'b0;
        idle_pct     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bucket edges, every protocol class, flag mixes, dropped ports.
        pkt(8'd0, 16'd0,     ETH_IPV4, PROTO_UDP,  32'h0, 16'd0, 8'h00);
        pkt(8'd0, 16'd63,    ETH_IPV4, PROTO_TCP,  32'hffffffff, 16'hffff, 8'h12);
        pkt(8'd0, 16'd64,    ETH_IPV4, PROTO_TCP,  32'h0, 16'd80, 8'h02);
        pkt(8'd0, 16'd127,   ETH_IPV4, PROTO_TCP,  32'h1, 16'd80, 8'h10);
        pkt(8'd0, 16'd128,   ETH_IPV4, PROTO_TCP,  32'h1, 16'd443, 8'h01);
        pkt(8'd0, 16'd511,   ETH_IPV4, PROTO_TCP,  32'h2, 16'd443, 8'h04);
        pkt(8'd0, 16'd1023,  ETH_IPV4, PROTO_TCP,  32'h3, 16'd22, 8'hff);
        pkt(8'd0, 16'd1499,  ETH_IPV4, PROTO_ICMP, 32'h4, 16'd9, 8'hff);
        pkt(8'd0, 16'd1500,  ETH_IPV4, 8'd99,      32'h5, 16'd9, 8'h00);
        pkt(8'd0, 16'hffff,  16'h86dd, PROTO_TCP,  32'h6, 16'd7, 8'h12);
        pkt(8'd0, 16'd255,   16'h0000, PROTO_UDP,  32'h7, 16'd7, 8'h00);
        pkt(8'd8,   16'd100, ETH_IPV4, PROTO_UDP, 32'h9, 16'd1, 8'h00);
        pkt(8'd255, 16'd100, ETH_IPV4, PROTO_UDP, 32'h9, 16'd1, 8'h00);
        pkt(8'd7, 16'd256,   ETH_IPV4, PROTO_UDP, 32'h8, 16'd53, 8'h00);
        dump(8'd0);
        dump(8'd7);
        dump(8'd255);
        dump(8'd0);

        // Fill one port past both distinct-set bounds, then dump it.
        for (int i = 0; i < 70; i++)
            pkt(8'd3, 16'd90, ETH_IPV4, PROTO_UDP, 32'hc0a80000 + 32'(i),
                16'(1000 + i), 8'h00);
        dump(8'd3);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 46 : (ph == 2) ? 29 : 46;
            for (int i = 0; i < 16; i++) random_item();
            // After the second phase, let the results drain before the next phase starts.
            if (ph == 1) wait_drained();
        end
        for (int p = 0; p < NUM_PORTS; p++) dump(8'(p));

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d dumps and %0d counter beats, %0d packets beyond a full IP set.",
                 dumps, beats, full_sets);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
